/* hdl/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg
// Types, constants and register codes shared by the force to duty converter.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int DUTY_W      = 16;
  localparam int FORCE_W     = 32;
  localparam int CFG_IDX_W   = 3;

  // thrust curve constants, q24
  localparam longint OFFS_Q24    = 64'd1267301;
  localparam longint B_Q24       = 64'd1135375;
  localparam longint A4_Q24      = 64'd6139970;
  localparam longint DUTY_SCALE2 = 64'd131070;
  localparam longint DUTY_FULL   = 64'd65535;
  localparam longint B_SQ        = B_Q24 * B_Q24;

  // datapath widths
  localparam int FQ_W     = FORCE_W + 1;
  localparam int PROD_W   = 58;
  localparam int RAD_W    = 56;
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = ROOT_W + 1;
  localparam int N_W      = 22;
  localparam int SCALE_W  = 17;
  localparam int NUM_W    = N_W + SCALE_W + 1;
  localparam int RECIP_K  = 24;
  localparam int M_W      = 20;
  localparam int EST_W    = N_W + M_W;
  localparam int Q_W      = 17;
  localparam int A4_W     = 23;
  localparam int QD_W     = Q_W + A4_W;

  // largest root excess whose duty does not saturate
  localparam longint NMAX_L    = ((DUTY_FULL + 64'd1) * A4_Q24 - 64'd1) / DUTY_SCALE2;
  localparam longint RECIP_M_L = (DUTY_SCALE2 << RECIP_K) / A4_Q24;

  localparam logic signed [FQ_W-1:0]   OFFS_S  = FQ_W'(OFFS_Q24);
  localparam logic signed [PROD_W-1:0] A4_S    = PROD_W'(A4_Q24);
  localparam logic signed [PROD_W-1:0] B_SQ_S  = PROD_W'(B_SQ);
  localparam logic [ROOT_W-1:0]        B_ROOT  = ROOT_W'(B_Q24);
  localparam logic [ROOT_W-1:0]        N_MAX   = ROOT_W'(NMAX_L);
  localparam logic [SCALE_W-1:0]       SCALE2  = SCALE_W'(DUTY_SCALE2);
  localparam logic [M_W-1:0]           RECIP_M = M_W'(RECIP_M_L);
  localparam logic [A4_W-1:0]          A4_U    = A4_W'(A4_Q24);
  localparam logic [DUTY_W-1:0]        DUTY_MAX = DUTY_W'(DUTY_FULL);
  localparam logic [DUTY_W-1:0]        MIN_DUTY_RESET = DUTY_W'(7000);

  // lane stages: offset, radicand, root steps, excess, three for the scaling
  localparam int LANE_LAT = 2 + SQ_STEPS + 1 + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVR_EN     = 3'd0,
    CFG_DUTY_ONE   = 3'd1,
    CFG_DUTY_TWO   = 3'd2,
    CFG_DUTY_THREE = 3'd3,
    CFG_DUTY_FOUR  = 3'd4,
    CFG_MIN_DUTY   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                      motors_on;
    logic signed [FORCE_W-1:0] force_one;
    logic signed [FORCE_W-1:0] force_two;
    logic signed [FORCE_W-1:0] force_three;
    logic signed [FORCE_W-1:0] force_four;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_two;
    logic [DUTY_W-1:0] duty_three;
    logic [DUTY_W-1:0] duty_four;
  } out_item_t;

  typedef struct packed {
    logic                                override_enable;
    logic [MOTOR_COUNT-1:0][DUTY_W-1:0] override_duty;
    logic [DUTY_W-1:0]                   min_duty;
  } cfg_t;

  typedef logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty_vec_t;

endpackage

/* hdl/mfp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mfp_cfg_regs
// Configuration register file: override selection, override duties, min duty.
// ----------------------------------------------------------------------------
module mfp_cfg_regs
  import mfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DUTY_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OVR_EN:     cfg_d.override_enable  = cfg_data_i[0];
        CFG_DUTY_ONE:   cfg_d.override_duty[0] = cfg_data_i;
        CFG_DUTY_TWO:   cfg_d.override_duty[1] = cfg_data_i;
        CFG_DUTY_THREE: cfg_d.override_duty[2] = cfg_data_i;
        CFG_DUTY_FOUR:  cfg_d.override_duty[3] = cfg_data_i;
        CFG_MIN_DUTY:   cfg_d.min_duty         = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.override_enable <= 1'b0;
      cfg_q.override_duty   <= '0;
      cfg_q.min_duty        <= MIN_DUTY_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/mfp_lane.sv */
// ----------------------------------------------------------------------------
// mfp_lane
// One motor: offset, radicand, pipelined bit-by-bit square root and
// reciprocal scaling to a 16-bit duty, saturated at full scale, no min clamp.
// ----------------------------------------------------------------------------
module mfp_lane
  import mfp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [FORCE_W-1:0] force_i,
  output logic [DUTY_W-1:0]         raw_o
);

  logic signed [FQ_W-1:0]   fq_d, fq_q;
  logic signed [PROD_W-1:0] rad_d;
  logic [RAD_W-1:0]         v_d, v_q;

  assign fq_d  = FQ_W'(force_i) + OFFS_S;
  assign rad_d = PROD_W'(fq_q) * A4_S + B_SQ_S;
  assign v_d   = (!rad_d[PROD_W-1] && (rad_d != '0)) ? rad_d[RAD_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fq_q <= fq_d;
      v_q  <= v_d;
    end
  end

  // square root, one result bit per stage
  logic [RAD_W-1:0]  sq_v_q    [SQ_STEPS];
  logic [ROOT_W-1:0] sq_root_q [SQ_STEPS];
  logic [REM_W-1:0]  sq_rem_q  [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic [RAD_W-1:0]  v_in, v_nx;
    logic [ROOT_W-1:0] root_in, root_nx;
    logic [REM_W-1:0]  rem_in, rem_nx;
    logic [REM_W+1:0]  trial, trial_sub;

    if (j == 0) begin : g_first
      assign v_in    = v_q;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign v_in    = sq_v_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
    end

    always_comb begin
      trial     = {rem_in, v_in[RAD_W-1 -: 2]};
      trial_sub = {1'b0, root_in, 2'b01};
      v_nx      = {v_in[RAD_W-3:0], 2'b00};
      if (trial >= trial_sub) begin
        rem_nx  = REM_W'(trial - trial_sub);
        root_nx = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nx  = REM_W'(trial);
        root_nx = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_v_q[j]    <= v_nx;
        sq_root_q[j] <= root_nx;
        sq_rem_q[j]  <= rem_nx;
      end
    end
  end

  // root excess over b, saturation check
  logic [ROOT_W-1:0] root, diff;
  logic [N_W-1:0]    nc_d, nc_q;
  logic              sat_d, sat_q;

  always_comb begin
    root  = sq_root_q[SQ_STEPS-1];
    diff  = root - B_ROOT;
    sat_d = 1'b0;
    nc_d  = '0;
    if (root > B_ROOT) begin
      if (diff > N_MAX) begin
        sat_d = 1'b1;
      end else begin
        nc_d = diff[N_W-1:0];
      end
    end
  end

  // scaling: num = 131070*n, estimate q = n*M >> K, then one correction
  logic [NUM_W-1:0] num_d, num_a_q, num_b_q;
  logic [EST_W-1:0] est_d, est_q;
  logic             sat_a_q, sat_b_q;
  logic [Q_W-1:0]   q_d, q_q, q_inc;
  logic [QD_W-1:0]  qd_d, qd_q;
  logic [DUTY_W-1:0] raw_d, raw_q;

  assign num_d = NUM_W'(nc_q) * NUM_W'(SCALE2);
  assign est_d = EST_W'(nc_q) * EST_W'(RECIP_M);
  assign q_d   = est_q[RECIP_K +: Q_W];
  assign qd_d  = QD_W'(Q_W'(q_d + Q_W'(1))) * QD_W'(A4_U);
  assign q_inc = Q_W'(q_q + Q_W'(1));

  always_comb begin
    if (sat_b_q) begin
      raw_d = DUTY_MAX;
    end else if (NUM_W'(num_b_q) >= NUM_W'(qd_q)) begin
      raw_d = q_inc[DUTY_W-1:0];
    end else begin
      raw_d = q_q[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nc_q    <= nc_d;
      sat_q   <= sat_d;
      num_a_q <= num_d;
      est_q   <= est_d;
      sat_a_q <= sat_q;
      num_b_q <= num_a_q;
      q_q     <= q_d;
      qd_q    <= qd_d;
      sat_b_q <= sat_a_q;
      raw_q   <= raw_d;
    end
  end

  assign raw_o = raw_q;

endmodule

/* hdl/mfp_merge.sv */
// ----------------------------------------------------------------------------
// mfp_merge
// Combines the lane duties with enable, min clamp and override into the
// result item, and holds the output register and skid stage.
// ----------------------------------------------------------------------------
module mfp_merge
  import mfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      lane_valid_i,
  input  logic      lane_on_i,
  input  duty_vec_t lane_raw_i,
  input  cfg_t      cfg_i,
  input  logic      out_ready_i,
  output logic      en_o,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  duty_vec_t duty_d, res_q, skid_q;
  logic      res_vld_q, skid_full_q;
  logic      en;

  assign en = !skid_full_q;

  always_comb begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      if (cfg_i.override_enable) begin
        duty_d[m] = cfg_i.override_duty[m];
      end else if (!lane_on_i) begin
        duty_d[m] = '0;
      end else if (lane_raw_i[m] < cfg_i.min_duty) begin
        duty_d[m] = cfg_i.min_duty;
      end else begin
        duty_d[m] = lane_raw_i[m];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q   <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      if (en) begin
        res_vld_q <= lane_valid_i;
        if (res_vld_q && !out_ready_i) begin
          skid_full_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        skid_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= duty_d;
      skid_q <= res_q;
    end
  end

  duty_vec_t sel;
  assign sel         = skid_full_q ? skid_q : res_q;
  assign out_valid_o = skid_full_q || res_vld_q;
  assign en_o        = en;

  assign out_data_o.duty_one   = sel[0];
  assign out_data_o.duty_two   = sel[1];
  assign out_data_o.duty_three = sel[2];
  assign out_data_o.duty_four  = sel[3];

endmodule

/* hdl/motor_force_to_pwm.sv */
// ----------------------------------------------------------------------------
// motor_force_to_pwm
// Converts four signed motor force commands into 16-bit PWM duties.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one item: the
// motors_on flag and four q24 forces. Output channel (out_valid_o /
// out_ready_i / out_data_o) returns one item of four duties per input item,
// in order. Configuration writes (cfg_valid_i / cfg_ready_o, cfg_index_i,
// cfg_data_i) are always taken; write them only while idle.
// One lane per motor runs a fully pipelined square root, one result bit per
// stage, so an item is accepted every cycle while the skid stage is empty.
// The path from acceptance to out_valid_o runs through the offset, radicand,
// 28 root, excess and three scaling stages, then the output register.
// When the receiver stalls, one result moves into a skid stage; the pipeline
// then holds and in_ready_o drops until the skid stage drains.
// Reset clears all valid state and loads the register reset values
// (override off, override duties 0, min duty 7000).
// ----------------------------------------------------------------------------
module motor_force_to_pwm
  import mfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DUTY_W-1:0]    cfg_data_i
);

  cfg_t      cfg;
  logic      en;
  duty_vec_t lane_raw;
  logic signed [FORCE_W-1:0] forces [MOTOR_COUNT];

  logic [LANE_LAT-1:0] vld_q, on_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = en;

  assign forces[0] = in_data_i.force_one;
  assign forces[1] = in_data_i.force_two;
  assign forces[2] = in_data_i.force_three;
  assign forces[3] = in_data_i.force_four;

  mfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
    mfp_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .force_i (forces[m]),
      .raw_o   (lane_raw[m])
    );
  end

  // item valid and enable flag alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LANE_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      on_q <= {on_q[LANE_LAT-2:0], in_data_i.motors_on};
    end
  end

  mfp_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lane_valid_i (vld_q[LANE_LAT-1]),
    .lane_on_i    (on_q[LANE_LAT-1]),
    .lane_raw_i   (lane_raw),
    .cfg_i        (cfg),
    .out_ready_i  (out_ready_i),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule

/* hdl/mfp_checker.sv */
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks on output flow control and the skid stage.
// ----------------------------------------------------------------------------
module mfp_checker
  import mfp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // input only blocked while a result waits
  a_block_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no pending result");

  // skid stage is empty again in the cycle after its result is taken
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("input still blocked after result taken");

  // blocking only follows a stall
  a_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input blocked without an output stall");

endmodule

bind motor_force_to_pwm mfp_checker u_chk (.*);
